>>> design/crc32_word_widened_bytes_assert.svh
// Assertion macros for the word-input CRC block.
// Each expects signals named clock and reset in scope.
`ifndef CRC32_WORD_WIDENED_BYTES_ASSERT_SVH
`define CRC32_WORD_WIDENED_BYTES_ASSERT_SVH

// same-cycle implication, quiet during reset
`define CRCW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crcw check failed");

// next-cycle implication, quiet during reset
`define CRCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crcw check failed");

// next-cycle implication that also holds across reset
`define CRCW_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("crcw check failed");

`endif

>>> design/crcw_pkg.sv
`default_nettype none

package crcw_pkg;

   localparam int CRC_W      = 32;
   localparam int BYTE_W     = 8;
   localparam int COEF_N     = CRC_W;
   localparam int COEF_IDX_W = $clog2(COEF_N);

   localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
   localparam logic [CRC_W-1:0] INIT_RESET = 32'hFFFF_FFFF;

   typedef logic [CRC_W-1:0] crc_type;
   typedef crc_type [COEF_N-1:0] coef_array_type;

   typedef enum logic [0:0] {
      CSR_POLYNOMIAL    = 1'b0,
      CSR_INITIAL_VALUE = 1'b1
   } csr_index_type;

   // one MSB-first shift step with reduction
   function automatic crc_type mul_x(input crc_type value, input crc_type poly);
      crc_type shifted;
      shifted = {value[CRC_W-2:0], 1'b0};
      return value[CRC_W-1] ? (shifted ^ poly) : shifted;
   endfunction

endpackage

`default_nettype wire

>>> design/crc32_word_widened_bytes.sv
// Running 32-bit CRC over a byte stream, MSB first, no reflection and no
// final XOR. One byte is taken per cycle while req_ready is high; a request
// is held in an input register, folded into the running CRC by an XOR tree
// over 32 stored coefficients, and on the byte marked last the CRC is
// registered into rsp_ after leaving the input register, while the running
// value reloads initial_value. The coefficients are rebuilt one per cycle
// from the polynomial, so req_ready stays low while they are rebuilt after
// reset and after every polynomial write.
`default_nettype none

module crc32_word_widened_bytes (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [crcw_pkg::BYTE_W-1:0]   req_data_byte,
   input  wire                          req_last_byte,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [crcw_pkg::CRC_W-1:0]   rsp_crc_result,
   input  wire                          csr_wen,
   input  wire [0:0]                    csr_index,
   input  wire [crcw_pkg::CRC_W-1:0]    csr_wdata
);

   crcw_pkg::crc_type               poly_ff;
   crcw_pkg::crc_type               init_ff;
   logic                            poly_write;
   crcw_pkg::coef_array_type        coef;
   logic                            tbl_ready;

   logic                            a_valid_ff;
   logic [crcw_pkg::BYTE_W-1:0]     a_byte_ff;
   logic                            a_last_ff;
   logic                            a_advance;
   logic                            accept;

   crcw_pkg::crc_type               running_ff;
   crcw_pkg::crc_type               running_in;
   crcw_pkg::crc_type               fold_out;
   logic                            rsp_valid_ff;
   crcw_pkg::crc_type               rsp_crc_ff;

   assign poly_write = csr_wen &&
                       (crcw_pkg::csr_index_type'(csr_index) == crcw_pkg::CSR_POLYNOMIAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= crcw_pkg::POLY_RESET;
         init_ff <= crcw_pkg::INIT_RESET;
      end else if (csr_wen) begin
         unique case (crcw_pkg::csr_index_type'(csr_index))
            crcw_pkg::CSR_POLYNOMIAL:    poly_ff <= csr_wdata;
            crcw_pkg::CSR_INITIAL_VALUE: init_ff <= csr_wdata;
         endcase
      end
   end

   crcw_coef_table u_coef_table (
      .clock      (clock),
      .reset      (reset),
      .start      (poly_write),
      .start_poly (csr_wdata),
      .poly       (poly_ff),
      .coef       (coef),
      .ready      (tbl_ready)
   );

   assign a_advance = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = tbl_ready && (!a_valid_ff || a_advance);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (a_advance) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_byte_ff <= req_data_byte;
         a_last_ff <= req_last_byte;
      end
   end

   crcw_fold u_fold (
      .crc_in    (running_ff),
      .data_byte (a_byte_ff),
      .coef      (coef),
      .crc_out   (fold_out)
   );

   // the last byte of a message hands its CRC out and restarts the register
   assign running_in = a_last_ff ? init_ff : fold_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= crcw_pkg::INIT_RESET;
      end else if (a_advance) begin
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_advance && a_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_advance && a_last_ff) begin
         rsp_crc_ff <= fold_out;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_crc_result = rsp_crc_ff;

endmodule

`default_nettype wire

>>> design/crcw_coef_table.sv
`default_nettype none

// Builds coef[i] = x^(32+i) mod P, one entry a cycle, after reset or a
// polynomial write. Entry 0 is the polynomial itself.
module crcw_coef_table (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire crcw_pkg::crc_type   start_poly,
   input  wire crcw_pkg::crc_type   poly,
   output crcw_pkg::coef_array_type coef,
   output logic                     ready
);

   logic                                busy_ff;
   logic                                busy_in;
   logic [crcw_pkg::COEF_IDX_W-1:0]     idx_ff;
   logic [crcw_pkg::COEF_IDX_W-1:0]     idx_in;
   crcw_pkg::crc_type                   gen_ff;
   crcw_pkg::crc_type                   gen_in;
   crcw_pkg::coef_array_type            coef_ff;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      gen_in  = gen_ff;
      priority if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         gen_in  = start_poly;
      end else if (busy_ff) begin
         idx_in = idx_ff + 1'b1;
         gen_in = crcw_pkg::mul_x(gen_ff, poly);
         if (idx_ff == crcw_pkg::COEF_IDX_W'(crcw_pkg::COEF_N - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
         gen_ff  <= crcw_pkg::POLY_RESET;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         gen_ff  <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         coef_ff[idx_ff] <= gen_ff;
      end
   end

   assign coef  = coef_ff;
   assign ready = !busy_ff;

endmodule

`default_nettype wire

>>> design/crcw_fold.sv
`default_nettype none

// Folds one byte into the CRC: (crc ^ byte) * x^32 mod P as an XOR tree
// over the precomputed coefficients.
module crcw_fold (
   input  wire crcw_pkg::crc_type        crc_in,
   input  wire [crcw_pkg::BYTE_W-1:0]    data_byte,
   input  wire crcw_pkg::coef_array_type coef,
   output crcw_pkg::crc_type             crc_out
);

   crcw_pkg::crc_type word;
   crcw_pkg::crc_type acc;

   always_comb begin
      word = crc_in ^ {{(crcw_pkg::CRC_W - crcw_pkg::BYTE_W){1'b0}}, data_byte};
      acc  = '0;
      for (int i = 0; i < crcw_pkg::COEF_N; i++) begin
         if (word[i]) begin
            acc = acc ^ coef[i];
         end
      end
   end

   assign crc_out = acc;

endmodule

`default_nettype wire

>>> design/crcw_checker.sv
`default_nettype none
`include "crc32_word_widened_bytes_assert.svh"

module crcw_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_valid,
   input wire                        req_ready,
   input wire                        req_last_byte,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input wire [crcw_pkg::CRC_W-1:0]  rsp_crc_result,
   input wire                        csr_wen,
   input wire [0:0]                  csr_index
);

   logic poly_wr;
   logic last_accept;

   assign poly_wr     = csr_wen && (csr_index == crcw_pkg::CSR_POLYNOMIAL);
   assign last_accept = req_valid && req_ready && req_last_byte;

   // coefficient rebuild keeps requests out after reset
   `CRCW_ASSERT_NEXT_ALWAYS(a_reset_blocks_req, reset, !req_ready)

   // and after a polynomial write
   `CRCW_ASSERT_NEXT(a_poly_blocks_req, poly_wr, !req_ready)

   // a fresh response only ever follows an accepted last byte, by way of the input register and the response register
   `CRCW_ASSERT_NOW(a_rsp_from_last, $rose(rsp_valid), $past(last_accept, 2))

   // a stalled response holds its value
   `CRCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_crc_result))

endmodule

bind crc32_word_widened_bytes crcw_checker u_crcw_checker (.*);

`default_nettype wire

>>> verif/tb_crc32_word_widened_bytes.sv
`timescale 1ns / 100ps

module tb_crc32_word_widened_bytes;

   localparam int PLAN_ROWS  = 22;
   localparam int PHASES     = 5;
   localparam int PHASE_REQS = 110;
   localparam int HOLD_LEN   = 300;

   typedef enum logic {
      ROW_SEND,
      ROW_CSR_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      crcw_pkg::csr_index_type idx;
      crcw_pkg::crc_type       value;
      logic [7:0]              data;
      logic                    last;
      logic                    typed;
      crcw_pkg::crc_type       want;
   } plan_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [crcw_pkg::BYTE_W-1:0] req_data_byte = '0;
   logic                        req_last_byte = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   crcw_pkg::crc_type           rsp_crc_result;
   logic                        csr_wen = 1'b0;
   crcw_pkg::csr_index_type     csr_index = crcw_pkg::CSR_POLYNOMIAL;
   crcw_pkg::crc_type           csr_wdata = '0;

   // predictor state
   crcw_pkg::crc_type crc_poly    = crcw_pkg::POLY_RESET;
   crcw_pkg::crc_type crc_init    = crcw_pkg::INIT_RESET;
   crcw_pkg::crc_type crc_running = crcw_pkg::INIT_RESET;
   crcw_pkg::crc_type crc_expected[$];

   int fail_count    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   bit start_hold    = 1'b0;

   // directed requests; expected CRCs typed in only where obvious
   plan_row_type plan[PLAN_ROWS] = '{
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h00, 1'b1, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'hFF, 1'b0, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h80, 1'b0, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h01, 1'b1, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h55, 1'b0, 1'b0, 32'h0},
      // initial value changed mid-message: running CRC must be untouched
      '{ROW_CSR_WRITE, crcw_pkg::CSR_INITIAL_VALUE, 32'h0,   8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'hAA, 1'b1, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h00, 1'b1, 1'b1, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h3C, 1'b0, 1'b0, 32'h0},
      // zero polynomial mid-message: 32 plain shifts clear everything
      '{ROW_CSR_WRITE, crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'hC3, 1'b1, 1'b1, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'hFF, 1'b1, 1'b1, 32'h0},
      '{ROW_CSR_WRITE, crcw_pkg::CSR_POLYNOMIAL,    '1,      8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR_WRITE, crcw_pkg::CSR_INITIAL_VALUE, '1,      8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'hFF, 1'b1, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h7F, 1'b1, 1'b0, 32'h0},
      '{ROW_CSR_WRITE, crcw_pkg::CSR_POLYNOMIAL,    crcw_pkg::POLY_RESET,
        8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR_WRITE, crcw_pkg::CSR_INITIAL_VALUE, crcw_pkg::INIT_RESET,
        8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h12, 1'b0, 1'b0, 32'h0},
      '{ROW_SEND,      crcw_pkg::CSR_POLYNOMIAL,    32'h0,   8'h34, 1'b1, 1'b0, 32'h0}
   };

   int send_idle_tab[PHASES] = '{0, 53, 0, 8, 0};
   int stall_tab[PHASES]     = '{0, 0, 53, 8, 0};
   int last_odds_tab[PHASES] = '{6, 6, 6, 5, 2};

   crc32_word_widened_bytes i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_crc_result (rsp_crc_result),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // byte zero-extended into the low end, then 32 MSB-first steps
   function automatic crcw_pkg::crc_type crc_fold(input crcw_pkg::crc_type crc,
                                                  input logic [7:0] data,
                                                  input crcw_pkg::crc_type poly);
      crcw_pkg::crc_type acc;
      acc = crc ^ {24'b0, data};
      for (int k = 0; k < crcw_pkg::CRC_W; k++) begin
         if (acc[crcw_pkg::CRC_W-1]) begin
            acc = {acc[crcw_pkg::CRC_W-2:0], 1'b0} ^ poly;
         end else begin
            acc = {acc[crcw_pkg::CRC_W-2:0], 1'b0};
         end
      end
      return acc;
   endfunction

   function automatic crcw_pkg::crc_type pick_word(input crcw_pkg::crc_type usual);
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return usual;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input crcw_pkg::crc_type got,
                                  input crcw_pkg::crc_type want);
      $display("ERROR %0t: %s: got %h, want %h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic send_byte(input logic [7:0] data, input logic last,
                            input logic typed, input crcw_pkg::crc_type want);
      crcw_pkg::crc_type folded;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      folded = crc_fold(crc_running, data, crc_poly);
      if (last) begin
         crc_expected.push_back(typed ? want : folded);
         crc_running = crc_init;
      end else begin
         crc_running = folded;
      end
   endtask

   // only once the block has drained; a byte without a result may still be in flight
   task automatic write_csr(input crcw_pkg::csr_index_type idx,
                            input crcw_pkg::crc_type value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (crc_expected.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (idx == crcw_pkg::CSR_POLYNOMIAL) begin
         crc_poly = value;
      end else begin
         crc_init = value;
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (start_hold) begin
         hold_left  = HOLD_LEN;
         start_hold = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      crcw_pkg::crc_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (crc_expected.size() == 0) begin
            report_mismatch("result with none pending", rsp_crc_result, '0);
         end else begin
            want = crc_expected.pop_front();
            if (rsp_crc_result !== want) begin
               report_mismatch("crc_result", rsp_crc_result, want);
            end
         end
      end
   end

   initial begin
      #200000;
      $display("crc32_word_widened_bytes: mismatch");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (plan[r].kind == ROW_CSR_WRITE) begin
            write_csr(plan[r].idx, plan[r].value);
         end else begin
            send_byte(plan[r].data, plan[r].last, plan[r].typed, plan[r].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         write_csr(crcw_pkg::CSR_POLYNOMIAL, pick_word(crcw_pkg::POLY_RESET));
         write_csr(crcw_pkg::CSR_INITIAL_VALUE, pick_word(crcw_pkg::INIT_RESET));
         send_idle_pct = send_idle_tab[p];
         stall_pct     = stall_tab[p];
         if (p == PHASES - 1) begin
            // keep offering requests while results back up
            @(posedge clock);
            start_hold = 1'b1;
         end
         for (int n = 0; n < PHASE_REQS; n++) begin
            send_byte(8'($urandom_range(255)), $urandom_range(last_odds_tab[p] - 1) == 0,
                      1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (crc_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("crc32_word_widened_bytes: match");
      end else begin
         $display("crc32_word_widened_bytes: mismatch");
      end
      $finish;
   end

endmodule
